// ===== design/bwsp_pkg.sv =====
// Package for the big-integer word stream properties block.
// Holds the transaction payload types and the shared constants; no dependencies.
`default_nettype none

package bwsp_pkg;

    localparam int unsigned MAX_WORDS_DEFAULT = 1024;
    localparam logic [63:0] HASH_INIT = 64'h8484_8484_8484_8484;

    localparam int unsigned BIT_LENGTH_W = 17;
    localparam int unsigned USED_WORDS_W = 11;
    localparam int unsigned TRAIL_ZEROS_W = 16;

    typedef struct packed {
        logic [63:0] word;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        logic [BIT_LENGTH_W-1:0]  bit_length;
        logic [USED_WORDS_W-1:0]  used_words;
        logic [63:0]              hash_value;
        logic                     is_zero;
        logic                     is_one;
        logic                     is_even;
        logic [TRAIL_ZEROS_W-1:0] trailing_zeros;
        logic                     is_pow2;
        logic                     too_long;
    } t_out_item;

    // Per-word scan result passed from the zero counter to the top level.
    typedef struct packed {
        logic       nonzero;
        logic [5:0] lead_zeros;
        logic [5:0] trail_zeros;
    } t_word_scan;

endpackage : bwsp_pkg

`default_nettype wire

// ===== design/bwsp_zero_count.sv =====
// Leading and trailing zero counter for one 64-bit word.
// Depends on bwsp_pkg for the t_word_scan result type.
`default_nettype none

module bwsp_zero_count
    import bwsp_pkg::*;
(
    input  wire logic [63:0] i_word,
    output t_word_scan       o_scan
);

    logic [63:0] rev_word;

    // Six halving steps; a zero word is never used by the caller.
    function automatic logic [5:0] count_lead(input logic [63:0] v);
        logic [63:0] cur;
        logic [5:0]  n;
        cur = v;
        n   = '0;
        for (int k = 5; k >= 0; k--) begin
            if ((cur >> (64 - (1 << k))) == 64'd0) begin
                n[k] = 1'b1;
                cur  = cur << (1 << k);
            end
        end
        return n;
    endfunction

    always_comb begin
        for (int i = 0; i < 64; i++) begin
            rev_word[i] = i_word[63 - i];
        end
    end

    assign o_scan.nonzero     = (i_word != 64'd0);
    assign o_scan.lead_zeros  = count_lead(i_word);
    assign o_scan.trail_zeros = count_lead(rev_word);

endmodule : bwsp_zero_count

`default_nettype wire

// ===== design/bignum_word_stream_properties_top.sv =====
// Top level of the big-integer word stream properties block.
// Depends on bwsp_pkg and bwsp_zero_count.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (t_out_item)
//
// A new input transaction can be accepted in every cycle, except while a closing
// word waits in the input register. While a word sits in the input register, the
// per-word update (rotate, XOR, zero counts) and the closing computation run
// combinationally into the state and result registers; a closing word's result
// is registered as the word leaves the input register. Reset is synchronous and
// active low; it clears the stream state and both valid flags. While a finished
// result waits on the output, words that do not close a number still flow; only
// a closing word in the input register waits, and with it the input channel.
`default_nettype none

module bignum_word_stream_properties_top
    import bwsp_pkg::*;
#(
    parameter int unsigned MAX_WORDS = MAX_WORDS_DEFAULT
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    // Position counters hold values up to MAX_WORDS; bit counts add six bits.
    localparam int unsigned POS_W  = $clog2(MAX_WORDS + 1);
    localparam int unsigned FULL_W = POS_W + 6;
    localparam int unsigned BITS_W = (FULL_W > BIT_LENGTH_W) ? FULL_W : BIT_LENGTH_W;
    localparam int unsigned USED_W = (POS_W > USED_WORDS_W) ? POS_W : USED_WORDS_W;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_WORDS);

    // Input register.
    logic     r_s1_valid;
    t_in_item r_s1_data;
    logic     s1_advance;
    logic     s1_fire;

    // Stream state.
    logic [63:0]       r_running_hash, n_running_hash;
    logic [63:0]       r_hash_at_top, n_hash_at_top;
    logic [POS_W-1:0]  r_word_pos, n_word_pos;
    logic [POS_W-1:0]  r_top_pos, n_top_pos;
    logic [5:0]        r_top_lz, n_top_lz;
    logic              r_seen_nonzero, n_seen_nonzero;
    logic [FULL_W-1:0] r_low_zeros, n_low_zeros;
    logic              r_first_clear, n_first_clear;
    logic              r_overflowed, n_overflowed;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item n_out_data;

    t_word_scan scan;

    logic [FULL_W-1:0] bits_full;
    logic [FULL_W-1:0] tz_full;
    logic [BITS_W-1:0] bits_wide;
    logic [BITS_W-1:0] tz_wide;
    logic [USED_W-1:0] used_wide;
    logic              res_zero;
    logic              res_one;
    logic              res_pow2;

    // A closing word may only move on when the result register is free.
    assign s1_advance  = !r_s1_data.last_word || !r_out_valid || i_out_ready;
    assign s1_fire     = r_s1_valid && s1_advance;
    assign o_in_ready  = !r_s1_valid || s1_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    bwsp_zero_count u_zero_count (
        .i_word (r_s1_data.word),
        .o_scan (scan)
    );

    // Per-word state update as the number is built up.
    always_comb begin
        n_running_hash = r_running_hash;
        n_hash_at_top  = r_hash_at_top;
        n_word_pos     = r_word_pos;
        n_top_pos      = r_top_pos;
        n_top_lz       = r_top_lz;
        n_seen_nonzero = r_seen_nonzero;
        n_low_zeros    = r_low_zeros;
        n_first_clear  = r_first_clear;
        n_overflowed   = r_overflowed;
        if (r_word_pos < MAX_POS) begin
            n_running_hash = {r_running_hash[60:0], r_running_hash[63:61]}
                             ^ r_s1_data.word;
            if (r_word_pos == '0) begin
                n_first_clear = !r_s1_data.word[0];
            end
            if (scan.nonzero) begin
                n_hash_at_top = n_running_hash;
                n_top_pos     = r_word_pos + POS_W'(1);
                n_top_lz      = scan.lead_zeros;
                if (!r_seen_nonzero) begin
                    n_low_zeros    = {r_word_pos, scan.trail_zeros};
                    n_seen_nonzero = 1'b1;
                end
            end
            n_word_pos = r_word_pos + POS_W'(1);
        end else begin
            n_overflowed = 1'b1;
        end
    end

    // Closing computation from the updated state.
    always_comb begin
        res_zero  = !n_seen_nonzero;
        bits_full = res_zero ? '0
                             : ({n_top_pos, 6'd0} - FULL_W'(n_top_lz));
        res_one   = (bits_full == FULL_W'(1));
        tz_full   = (res_zero || res_one) ? '0 : n_low_zeros;
        if (res_zero) begin
            res_pow2 = 1'b0;
        end else if (res_one) begin
            res_pow2 = 1'b1;
        end else begin
            res_pow2 = ((n_low_zeros + FULL_W'(1)) == bits_full);
        end
        bits_wide = BITS_W'(bits_full);
        tz_wide   = BITS_W'(tz_full);
        used_wide = res_zero ? '0 : USED_W'(n_top_pos);

        n_out_data.bit_length      = bits_wide[BIT_LENGTH_W-1:0];
        n_out_data.used_words      = used_wide[USED_WORDS_W-1:0];
        n_out_data.hash_value      = res_zero ? 64'd0 : n_hash_at_top;
        n_out_data.is_zero         = res_zero;
        n_out_data.is_one          = res_one;
        n_out_data.is_even         = res_zero || n_first_clear;
        n_out_data.trailing_zeros  = tz_wide[TRAIL_ZEROS_W-1:0];
        n_out_data.is_pow2         = res_pow2;
        n_out_data.too_long        = n_overflowed;
    end

    // Control and stream state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_running_hash <= HASH_INIT;
            r_hash_at_top  <= '0;
            r_word_pos     <= '0;
            r_top_pos      <= '0;
            r_top_lz       <= '0;
            r_seen_nonzero <= 1'b0;
            r_low_zeros    <= '0;
            r_first_clear  <= 1'b1;
            r_overflowed   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_fire && r_s1_data.last_word) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_fire) begin
                if (r_s1_data.last_word) begin
                    // The number is closed; start the next one from scratch.
                    r_running_hash <= HASH_INIT;
                    r_hash_at_top  <= '0;
                    r_word_pos     <= '0;
                    r_top_pos      <= '0;
                    r_top_lz       <= '0;
                    r_seen_nonzero <= 1'b0;
                    r_low_zeros    <= '0;
                    r_first_clear  <= 1'b1;
                    r_overflowed   <= 1'b0;
                end else begin
                    r_running_hash <= n_running_hash;
                    r_hash_at_top  <= n_hash_at_top;
                    r_word_pos     <= n_word_pos;
                    r_top_pos      <= n_top_pos;
                    r_top_lz       <= n_top_lz;
                    r_seen_nonzero <= n_seen_nonzero;
                    r_low_zeros    <= n_low_zeros;
                    r_first_clear  <= n_first_clear;
                    r_overflowed   <= n_overflowed;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_data <= i_in_data;
        end
        if (s1_fire && r_s1_data.last_word) begin
            r_out_data <= n_out_data;
        end
    end

    // The word counter never runs past the maximum.
    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_pos <= MAX_POS)
        else $error("word position beyond the maximum");

    // A closing word that moves on leaves a fresh stream state behind.
    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_data.last_word) |=>
            (r_word_pos == '0 && !r_seen_nonzero && r_running_hash == HASH_INIT))
        else $error("stream state not cleared after a closing word");

    // A stalled closing word stays in the input register.
    a_close_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_advance) |=> (r_s1_valid && r_s1_data.last_word))
        else $error("stalled closing word was lost");

    // A zero result carries no hash and no length, is even and is no power of two.
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.is_zero) |->
            (r_out_data.hash_value == 64'd0 && r_out_data.bit_length == '0
             && r_out_data.is_even && !r_out_data.is_pow2))
        else $error("inconsistent zero result");

endmodule : bignum_word_stream_properties_top

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for bignum_word_stream_properties_top.
// Depends on bwsp_pkg for the payload types and the hash seed, and on the top module.
// It streams numbers into the block, predicts each result and checks it.
`default_nettype none

module testbench;
    import bwsp_pkg::*;

    // The receiver's stall behavior changes from phase to phase: sometimes it
    // never stalls, sometimes it flips a coin, sometimes it stalls rarely, and
    // sometimes it stalls for long stretches and takes a result only now and then.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_MOSTLY,
        READY_SLOW
    } t_ready_mode;

    localparam int unsigned HALF_PERIOD = 6;
    localparam int unsigned TIMEOUT_CYCLES = 400000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned RANDOM_WORDS = 150;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    bignum_word_stream_properties_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock with a period of twelve time units.
    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    // Properties expected for every number whose closing word has been accepted,
    // oldest first.
    t_out_item expected_props[$];
    int unsigned mismatch_count = 0;

    // Running description of the number being received, kept the same way the block
    // keeps it: a hash over the counted words, a snapshot of that hash at the last
    // nonzero word, and the counts that give the bit length and trailing zeros.
    logic [63:0] acc_hash;
    logic [63:0] acc_top_hash;
    int unsigned acc_pos;
    int unsigned acc_top_pos;
    int unsigned acc_top_lz;
    logic        acc_seen;
    int unsigned acc_low_zeros;
    logic        acc_first_clear;
    logic        acc_over;

    // Sender burst bookkeeping: words left in the current burst.
    int unsigned burst_left = 0;

    // Receiver stall pattern state.
    t_ready_mode ready_mode = READY_ALWAYS;
    int unsigned ready_phase_left = 0;
    int unsigned ready_tick = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("mismatch: %s got %h expected %h at %0t", what, got, want, $time);
    endtask

    task automatic clear_number();
        acc_hash = HASH_INIT;
        acc_top_hash = '0;
        acc_pos = 0;
        acc_top_pos = 0;
        acc_top_lz = 0;
        acc_seen = 1'b0;
        acc_low_zeros = 0;
        acc_first_clear = 1'b1;
        acc_over = 1'b0;
    endtask

    // Folds one accepted word into the running description. A closing word turns
    // the description into the expected properties and starts a fresh number.
    task automatic accumulate_word(input t_in_item item);
        logic [63:0] w;
        int unsigned lz;
        int unsigned tz;
        int unsigned bits;
        logic        zero;
        logic        one;
        t_out_item   res;
        w = item.word;
        if (acc_pos < MAX_WORDS_DEFAULT) begin
            acc_hash = {acc_hash[60:0], acc_hash[63:61]} ^ w;
            if (acc_pos == 0) begin
                acc_first_clear = ~w[0];
            end
            if (w != '0) begin
                lz = 0;
                while (!w[63 - lz]) begin
                    lz++;
                end
                acc_top_hash = acc_hash;
                acc_top_pos = acc_pos + 1;
                acc_top_lz = lz;
                if (!acc_seen) begin
                    tz = 0;
                    while (!w[tz]) begin
                        tz++;
                    end
                    acc_low_zeros = acc_pos * 64 + tz;
                    acc_seen = 1'b1;
                end
            end
            acc_pos++;
        end else begin
            // Words past the limit only mark the number as too long.
            acc_over = 1'b1;
        end
        if (item.last_word) begin
            zero = ~acc_seen;
            bits = zero ? 0 : acc_top_pos * 64 - acc_top_lz;
            one = (bits == 1);
            tz = (zero || one) ? 0 : acc_low_zeros;
            res.bit_length = bits[BIT_LENGTH_W-1:0];
            res.used_words = zero ? '0 : acc_top_pos[USED_WORDS_W-1:0];
            res.hash_value = zero ? '0 : acc_top_hash;
            res.is_zero = zero;
            res.is_one = one;
            res.is_even = zero | acc_first_clear;
            res.trailing_zeros = tz[TRAIL_ZEROS_W-1:0];
            if (zero) begin
                res.is_pow2 = 1'b0;
            end else if (one) begin
                res.is_pow2 = 1'b1;
            end else begin
                res.is_pow2 = (tz + 1 == bits);
            end
            res.too_long = acc_over;
            expected_props.push_back(res);
            clear_number();
        end
    endtask

    // Sends one word. The sender works in bursts; between bursts it may drop
    // valid for a random number of cycles. Valid is never lowered right after
    // an acceptance, so back-to-back transactions keep it high without a glitch.
    task automatic send_word(input logic [63:0] word, input logic last_word);
        int unsigned gap;
        t_in_item item;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 128)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        item.word = word;
        item.last_word = last_word;
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        accumulate_word(item);
    endtask

    // Holds the sender off until every expected result has been taken. The
    // first wait is unconditional so that valid is lowered in a step of its own.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_props.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Word content with a bias toward the interesting shapes: zero words,
    // single set bits, all ones, small values and fully random words.
    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 7))
            0, 1: pick_word = '0;
            2: pick_word = 64'd1 << $urandom_range(0, 63);
            3: pick_word = '1;
            4: pick_word = 64'($urandom_range(0, 15));
            default: pick_word = {$urandom, $urandom};
        endcase
    endfunction

    // Short numbers that hit the edges: zero, one, powers of two at word
    // boundaries, full words and high zero words that must stay out of the hash.
    task automatic test_corner_numbers();
        send_word(64'd0, 1'b1);
        send_word(64'd1, 1'b1);
        send_word('1, 1'b1);
        send_word(64'h8000_0000_0000_0000, 1'b1);
        send_word(64'd6, 1'b1);
        send_word(64'd0, 1'b0);
        send_word(64'd0, 1'b1);
        send_word(64'd0, 1'b0);
        send_word(64'd1, 1'b1);
        send_word(64'd5, 1'b0);
        send_word(64'd0, 1'b0);
        send_word(64'd0, 1'b1);
        send_word(64'd1, 1'b0);
        send_word(64'd0, 1'b0);
        send_word(64'd0, 1'b1);
        send_word(64'd0, 1'b0);
        send_word(64'h0000_0001_0000_0000, 1'b0);
        send_word(64'h5555_aaaa_5555_aaaa, 1'b0);
        send_word(64'd0, 1'b1);
        send_word(64'd3, 1'b0);
        send_word('1, 1'b1);
        wait_results_drained();
    endtask

    // Random numbers, mostly short, some with trailing high zero words. The
    // sender pauses for a full drain every so often.
    task automatic test_random_numbers();
        int unsigned sent;
        int unsigned numbers;
        int unsigned len;
        int unsigned high_zeros;
        int unsigned pick;
        logic [63:0] w;
        sent = 0;
        numbers = 0;
        while (sent < RANDOM_WORDS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                len = $urandom_range(1, 4);
            end else if (pick < 9) begin
                len = $urandom_range(5, 16);
            end else begin
                len = $urandom_range(17, 48);
            end
            high_zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            for (int unsigned k = 0; k < len; k++) begin
                w = (k + high_zeros >= len) ? '0 : pick_word();
                send_word(w, k == len - 1);
            end
            sent += len;
            numbers++;
            if (numbers % 60 == 0) begin
                wait_results_drained();
            end
        end
        wait_results_drained();
    endtask

    // A number one word past the limit: the last counted word carries only its
    // top bit, so the length and trailing zero counts reach their largest values,
    // and the closing word is nonzero but ignored. A zero number afterwards shows
    // that the state starts fresh.
    task automatic test_word_limit();
        for (int unsigned k = 0; k <= MAX_WORDS_DEFAULT; k++) begin
            send_word((k == MAX_WORDS_DEFAULT - 1) ? 64'h8000_0000_0000_0000
                      : ((k == MAX_WORDS_DEFAULT) ? '1 : 64'd0),
                      k == MAX_WORDS_DEFAULT);
        end
        send_word(64'd0, 1'b1);
        wait_results_drained();
    endtask

    // Receiver stall pattern. Each phase lasts a random number of cycles and
    // picks one mode; ready is held low through reset.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (ready_phase_left == 0) begin
                ready_mode <= t_ready_mode'($urandom_range(0, 3));
                ready_phase_left <= $urandom_range(10, 150);
            end else begin
                ready_phase_left <= ready_phase_left - 1;
            end
            ready_tick <= ready_tick + 1;
            case (ready_mode)
                READY_ALWAYS: i_out_ready <= 1'b1;
                READY_RANDOM: i_out_ready <= 1'($urandom_range(0, 1));
                READY_MOSTLY: i_out_ready <= ($urandom_range(0, 7) != 0);
                READY_SLOW:   i_out_ready <= (ready_tick % 24 == 0);
                default:      i_out_ready <= 1'b1;
            endcase
        end
    end

    // Result checker: every accepted output transaction is compared field by
    // field with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_props.size() == 0) begin
                report_mismatch("result with nothing expected", o_out_data.hash_value, '0);
            end else begin
                want = expected_props.pop_front();
                if (o_out_data.bit_length !== want.bit_length)
                    report_mismatch("bit_length", o_out_data.bit_length, want.bit_length);
                if (o_out_data.used_words !== want.used_words)
                    report_mismatch("used_words", o_out_data.used_words, want.used_words);
                if (o_out_data.hash_value !== want.hash_value)
                    report_mismatch("hash_value", o_out_data.hash_value, want.hash_value);
                if (o_out_data.is_zero !== want.is_zero)
                    report_mismatch("is_zero", o_out_data.is_zero, want.is_zero);
                if (o_out_data.is_one !== want.is_one)
                    report_mismatch("is_one", o_out_data.is_one, want.is_one);
                if (o_out_data.is_even !== want.is_even)
                    report_mismatch("is_even", o_out_data.is_even, want.is_even);
                if (o_out_data.trailing_zeros !== want.trailing_zeros)
                    report_mismatch("trailing_zeros", o_out_data.trailing_zeros,
                                    want.trailing_zeros);
                if (o_out_data.is_pow2 !== want.is_pow2)
                    report_mismatch("is_pow2", o_out_data.is_pow2, want.is_pow2);
                if (o_out_data.too_long !== want.too_long)
                    report_mismatch("too_long", o_out_data.too_long, want.too_long);
            end
        end
    end

    // Main sequence: reset once, run each test in turn, let the pipeline settle
    // and give the verdict.
    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        clear_number();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_numbers();
        test_random_numbers();
        test_word_limit();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_props.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("TB_ERROR");
        $finish;
    end

endmodule : testbench

`default_nettype wire
